// ===== design/gebd_pkg.sv =====
// Package for the GPIO edge binding debouncer: word types, codes, constants, helpers.
package gebd_pkg;

  localparam int SLOTS_DEF    = 8;
  localparam int MAX_BIND_PIN = 29;

  localparam logic [2:0] FN_EVENT = 3'd0;
  localparam logic [2:0] FN_ADD   = 3'd1;
  localparam logic [2:0] FN_REM   = 3'd2;
  localparam logic [2:0] FN_CLEAR = 3'd3;
  localparam logic [2:0] FN_TAKE  = 3'd4;

  localparam logic [1:0] EM_RISE   = 2'd0;
  localparam logic [1:0] EM_FALL   = 2'd1;
  localparam logic [1:0] EM_EITHER = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [4:0]  pin;
    logic        rise_seen;
    logic        fall_seen;
    logic [31:0] now_ms;
    logic [1:0]  edge_mode;
    logic [31:0] debounce_time;
  } in_word_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] slot_index;
    logic [7:0] fired_mask;
    logic [7:0] pending_mask;
    logic [1:0] pin_edge_mask;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // bit0 rise, bit1 fall
  function automatic logic [1:0] mode_bits(input logic [1:0] mode);
    logic [1:0] m;
    case (mode)
      EM_RISE:   m = 2'b01;
      EM_FALL:   m = 2'b10;
      EM_EITHER: m = 2'b11;
      default:   m = 2'b00;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] low8(input logic [31:0] v);
    return v[7:0];
  endfunction

  function automatic logic [2:0] low3(input logic [31:0] v);
    return v[2:0];
  endfunction

endpackage

// ===== design/gebd_deb_cmp.sv =====
// Shared debounce check: modulo 2^32 elapsed time against the slot's debounce time.
module gebd_deb_cmp (
  input  logic [31:0] now_ms,
  input  logic [31:0] last_ms,
  input  logic [31:0] deb_ms,
  output logic        pass
);

  logic [31:0] elapsed;

  assign elapsed = now_ms - last_ms;
  assign pass    = (deb_ms == 32'd0) || (elapsed >= deb_ms);

endmodule

// ===== design/gpio_edge_binding_debouncer.sv =====
// Top level of the GPIO edge binding debouncer: slot table, scan sequencer, result register.
//
// Input channel in_valid/in_ready/in_data carries one command word: an edge
// event on a pin, add or replace a binding, remove a binding, clear all
// bindings, or take the pending set. Output channel out_valid/out_ready/out_data
// returns exactly one result word per command.
// Edge event, add and remove walk the slot table one slot per cycle through a
// single subtract/compare unit: the result is loaded when the final step ends,
// which waits while the receiver stalls, and in_ready rises at that same edge.
// Clear all, take pending and the unused function codes skip the walk and go
// straight to the final step.
// in_ready is high only while the sequencer is idle.
// The result register frees the input side: a new command can be taken while
// a result waits; if the receiver still stalls when the next result is due,
// the sequencer holds in its final step until out_ready.
// Synchronous reset empties the table, clears every pending bit and drops
// out_valid.
module gpio_edge_binding_debouncer #(
  parameter int SLOTS = gebd_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gebd_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gebd_pkg::out_word_t out_data
);

  import gebd_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  state_t st_r, st_nxt;
  in_word_t cmd_r;
  logic [IW-1:0] idx_r;

  logic [SLOTS-1:0] used_r;
  logic [SLOTS-1:0] pend_r;
  logic [4:0]  pin_r  [SLOTS];
  logic [1:0]  edge_r [SLOTS];
  logic [31:0] deb_r  [SLOTS];
  logic [31:0] last_r [SLOTS];

  logic          hit_r, free_r;
  logic [IW-1:0] hit_idx_r, free_idx_r;
  logic [1:0]    acc_all_r, acc_rest_r;
  logic [SLOTS-1:0] fired_r;

  out_word_t out_r;
  logic      out_valid_r;

  logic in_acc, scan_en, fin_go, out_free;
  logic on_pin, edge_hit, deb_pass;
  logic [1:0] cur_mb;

  logic          add_ok;
  logic [IW-1:0] add_slot;
  logic [SLOTS-1:0] new_used, new_pend;
  out_word_t res;

  assign out_free = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.func inside {FN_EVENT, FN_ADD, FN_REM}) begin
            st_nxt = ST_SCAN;
          end else begin
            st_nxt = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (idx_r == LAST_IDX) st_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    scan_en  = 1'b0;
    fin_go   = 1'b0;
    case (st_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_SCAN:   scan_en  = 1'b1;
      ST_FINISH: fin_go   = out_free;
      default: ;
    endcase
  end

  // per-slot view for the scan
  assign cur_mb   = mode_bits(edge_r[idx_r]);
  assign on_pin   = used_r[idx_r] && (pin_r[idx_r] == cmd_r.pin);
  assign edge_hit = |(cur_mb & {cmd_r.fall_seen, cmd_r.rise_seen});

  gebd_deb_cmp u_deb (
    .now_ms  (cmd_r.now_ms),
    .last_ms (last_r[idx_r]),
    .deb_ms  (deb_r[idx_r]),
    .pass    (deb_pass)
  );

  // final step: table update and result word
  always_comb begin
    add_ok   = (cmd_r.pin <= 5'(MAX_BIND_PIN)) && (hit_r || free_r);
    add_slot = hit_r ? hit_idx_r : free_idx_r;
    new_used = used_r;
    new_pend = pend_r;
    res      = '0;
    res.ok   = 1'b1;
    case (cmd_r.func)
      FN_EVENT: begin
        res.fired_mask = low8(32'(fired_r));
      end
      FN_ADD: begin
        if (add_ok) begin
          new_used[add_slot] = 1'b1;
          new_pend[add_slot] = 1'b0;
          res.slot_index     = low3(32'(add_slot));
          res.pin_edge_mask  = acc_rest_r | mode_bits(cmd_r.edge_mode);
        end else begin
          res.ok             = 1'b0;
          res.pin_edge_mask  = acc_all_r;
        end
      end
      FN_REM: begin
        if (hit_r) begin
          new_used[hit_idx_r] = 1'b0;
          new_pend[hit_idx_r] = 1'b0;
          res.slot_index      = low3(32'(hit_idx_r));
        end else begin
          res.ok = 1'b0;
        end
        res.pin_edge_mask = acc_rest_r;
      end
      FN_CLEAR: begin
        new_used = '0;
        new_pend = '0;
      end
      FN_TAKE: begin
        new_pend = '0;
      end
      default: ;
    endcase
    if (cmd_r.func == FN_TAKE) begin
      res.pending_mask = low8(32'(used_r & pend_r));
    end else begin
      res.pending_mask = low8(32'(new_used & new_pend));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      used_r      <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (scan_en && cmd_r.func == FN_EVENT && on_pin && edge_hit && deb_pass) begin
        pend_r[idx_r] <= 1'b1;
      end
      if (fin_go) begin
        used_r      <= new_used;
        pend_r      <= new_pend;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // scan bookkeeping and slot payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r      <= in_data;
      idx_r      <= '0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
      hit_idx_r  <= '0;
      free_idx_r <= '0;
      acc_all_r  <= '0;
      acc_rest_r <= '0;
      fired_r    <= '0;
    end
    if (scan_en) begin
      if (idx_r != LAST_IDX) idx_r <= idx_r + IW'(1);
      if (on_pin) begin
        acc_all_r <= acc_all_r | cur_mb;
        if (!hit_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= idx_r;
        end else begin
          acc_rest_r <= acc_rest_r | cur_mb;
        end
      end
      if (!used_r[idx_r] && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= idx_r;
      end
      if (cmd_r.func == FN_EVENT && on_pin && edge_hit && deb_pass) begin
        last_r[idx_r] <= cmd_r.now_ms;
        if (!pend_r[idx_r]) fired_r[idx_r] <= 1'b1;
      end
    end
    if (fin_go) begin
      out_r <= res;
      if (cmd_r.func == FN_ADD && add_ok) begin
        pin_r[add_slot]  <= cmd_r.pin;
        edge_r[add_slot] <= cmd_r.edge_mode;
        deb_r[add_slot]  <= cmd_r.debounce_time;
        last_r[add_slot] <= 32'd0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> out_valid)
    else $error("result not presented after final step");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN && idx_r == LAST_IDX) |=> (st_r == ST_FINISH))
    else $error("scan did not end after last slot");

  a_fired_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FINISH) |-> ((fired_r & ~pend_r) == '0))
    else $error("fired slot not pending");

  a_hit_used: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN && hit_r) |-> used_r[hit_idx_r])
    else $error("matched slot not in use");

endmodule

// ===== tb/gebd_checker.sv =====
`timescale 1ns / 1ps
// Checker for the GPIO edge binding debouncer: slot-table predictor and result compare.
module gebd_checker #(
  parameter int NSLOT = gebd_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  gebd_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  gebd_pkg::out_word_t out_data,
  output int                  mismatches,
  output int                  due_count,
  output int                  results_checked,
  output int                  firing_results
);
  import gebd_pkg::*;

  logic        bind_live  [NSLOT];
  logic [4:0]  bind_pin   [NSLOT];
  logic [1:0]  bind_mode  [NSLOT];
  logic [31:0] bind_quiet [NSLOT];
  logic [31:0] bind_stamp [NSLOT];
  logic        bind_flag  [NSLOT];

  out_word_t due_results[$];
  out_word_t want;
  out_word_t got;
  out_word_t pred;

  // bit0 rise, bit1 fall
  function automatic logic [1:0] enabled_edges(input logic [1:0] m);
    return {(m == EM_FALL) || (m == EM_EITHER), (m == EM_RISE) || (m == EM_EITHER)};
  endfunction

  function automatic int first_on_pin(input logic [4:0] p);
    for (int i = 0; i < NSLOT; i++)
      if (bind_live[i] && bind_pin[i] == p) return i;
    return -1;
  endfunction

  function automatic int first_free();
    for (int i = 0; i < NSLOT; i++)
      if (!bind_live[i]) return i;
    return -1;
  endfunction

  function automatic logic [1:0] pin_edges(input logic [4:0] p);
    logic [1:0] m;
    m = 2'b00;
    for (int i = 0; i < NSLOT; i++)
      if (bind_live[i] && bind_pin[i] == p) m = m | enabled_edges(bind_mode[i]);
    return m;
  endfunction

  function automatic logic [7:0] live_pending();
    logic [31:0] m;
    m = '0;
    for (int i = 0; i < NSLOT; i++)
      if (bind_live[i] && bind_flag[i]) m[i] = 1'b1;
    return m[7:0];
  endfunction

  task automatic apply_command(input in_word_t c, output out_word_t r);
    logic [31:0] fired;
    logic [31:0] elapsed;
    logic [1:0]  en;
    logic        hit_edge;
    int          s;
    r = '0;
    r.ok = 1'b1;
    fired = '0;
    s = -1;
    case (c.func)
      FN_EVENT: begin
        for (int i = 0; i < NSLOT; i++) begin
          en = enabled_edges(bind_mode[i]);
          hit_edge = (c.rise_seen & en[0]) | (c.fall_seen & en[1]);
          elapsed = c.now_ms - bind_stamp[i];
          if (bind_live[i] && bind_pin[i] == c.pin && hit_edge &&
              !(bind_quiet[i] != 0 && elapsed < bind_quiet[i])) begin
            bind_stamp[i] = c.now_ms;
            if (!bind_flag[i]) fired[i] = 1'b1;
            bind_flag[i] = 1'b1;
          end
        end
        r.fired_mask = fired[7:0];
        r.pending_mask = live_pending();
      end
      FN_ADD: begin
        if (c.pin <= MAX_BIND_PIN) begin
          s = first_on_pin(c.pin);
          if (s < 0) s = first_free();
        end
        if (s < 0) begin
          r.ok = 1'b0;
        end else begin
          bind_live[s]  = 1'b1;
          bind_pin[s]   = c.pin;
          bind_mode[s]  = c.edge_mode;
          bind_quiet[s] = c.debounce_time;
          bind_stamp[s] = '0;
          bind_flag[s]  = 1'b0;
          r.slot_index  = 3'(s);
        end
        r.pin_edge_mask = pin_edges(c.pin);
        r.pending_mask = live_pending();
      end
      FN_REM: begin
        s = first_on_pin(c.pin);
        if (s < 0) begin
          r.ok = 1'b0;
        end else begin
          bind_live[s] = 1'b0;
          bind_flag[s] = 1'b0;
          r.slot_index = 3'(s);
        end
        r.pin_edge_mask = pin_edges(c.pin);
        r.pending_mask = live_pending();
      end
      FN_CLEAR: begin
        for (int i = 0; i < NSLOT; i++) begin
          bind_live[i] = 1'b0;
          bind_flag[i] = 1'b0;
        end
        r.pending_mask = '0;
      end
      FN_TAKE: begin
        r.pending_mask = live_pending();
        for (int i = 0; i < NSLOT; i++) bind_flag[i] = 1'b0;
      end
      default: begin
        r.pending_mask = live_pending();
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    $display("%0t mismatch in %s: got 0x%0h, predicted 0x%0h", $time, what, seen, wanted);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) begin
        bind_live[i]  = 1'b0;
        bind_pin[i]   = '0;
        bind_mode[i]  = '0;
        bind_quiet[i] = '0;
        bind_stamp[i] = '0;
        bind_flag[i]  = 1'b0;
      end
      due_results.delete();
      mismatches = 0;
      results_checked = 0;
      firing_results = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        got = out_data;
        if (due_results.size() == 0) begin
          report_mismatch("result word with nothing due", got, '0);
        end else begin
          want = due_results.pop_front();
          if (got.ok !== want.ok) report_mismatch("ok", got.ok, want.ok);
          if (got.slot_index !== want.slot_index)
            report_mismatch("slot_index", got.slot_index, want.slot_index);
          if (got.fired_mask !== want.fired_mask)
            report_mismatch("fired_mask", got.fired_mask, want.fired_mask);
          if (got.pending_mask !== want.pending_mask)
            report_mismatch("pending_mask", got.pending_mask, want.pending_mask);
          if (got.pin_edge_mask !== want.pin_edge_mask)
            report_mismatch("pin_edge_mask", got.pin_edge_mask, want.pin_edge_mask);
          if (want.fired_mask != 0) firing_results++;
        end
      end
      if (in_valid && in_ready) begin
        apply_command(in_data, pred);
        due_results.push_back(pred);
      end
    end
    due_count = due_results.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the GPIO edge binding debouncer: clock, reset, stimulus, verdict.
module tb;
  import gebd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 200;
  localparam int CHUNKS         = 9;
  localparam int CHUNK_WORDS    = 100;

  localparam logic [2:0] FN_SPARE5 = 3'd5;
  localparam logic [2:0] FN_SPARE6 = 3'd6;
  localparam logic [2:0] FN_SPARE7 = 3'd7;
  localparam logic [1:0] EM_NONE   = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  int mismatches;
  int due_count;
  int results_checked;
  int firing_results;

  bit          tx_idle_on;
  bit          rx_stall_on;
  bit          hold_off_req;
  int          quiet_cycles;
  int          stall_left;
  int          sent_by_func[8];
  logic [31:0] wall_ms;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  gpio_edge_binding_debouncer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  gebd_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .mismatches      (mismatches),
    .due_count       (due_count),
    .results_checked (results_checked),
    .firing_results  (firing_results)
  );

  always @(posedge clk) begin
    if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready))) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      if (!rx_stall_on) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic send_word(input in_word_t w);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent_by_func[w.func]++;
  endtask

  task automatic issue(input logic [2:0] f, input logic [4:0] p, input logic r,
                       input logic fl, input logic [31:0] t, input logic [1:0] m,
                       input logic [31:0] d);
    in_word_t w;
    w.func = f;
    w.pin = p;
    w.rise_seen = r;
    w.fall_seen = fl;
    w.now_ms = t;
    w.edge_mode = m;
    w.debounce_time = d;
    send_word(w);
  endtask

  function automatic in_word_t random_command();
    in_word_t w;
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) w.func = FN_EVENT;
    else if (r < 67) w.func = FN_ADD;
    else if (r < 77) w.func = FN_REM;
    else if (r < 79) w.func = FN_CLEAR;
    else if (r < 92) w.func = FN_TAKE;
    else if (r < 95) w.func = FN_SPARE5;
    else if (r < 98) w.func = FN_SPARE6;
    else w.func = FN_SPARE7;
    r = $urandom_range(0, 99);
    if (r < 70) w.pin = 5'($urandom_range(0, 3));
    else if (r < 80) w.pin = 5'($urandom_range(26, 31));
    else w.pin = 5'($urandom_range(0, 31));
    w.rise_seen = 1'($urandom_range(0, 1));
    w.fall_seen = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 85) wall_ms = wall_ms + $urandom_range(0, 150);
    else if (r < 95) wall_ms = wall_ms + $urandom;
    w.now_ms = (r >= 95) ? $urandom : wall_ms;
    w.edge_mode = 2'($urandom_range(0, 3));
    r = $urandom_range(0, 99);
    if (r < 30) w.debounce_time = '0;
    else if (r < 85) w.debounce_time = $urandom_range(1, 200);
    else if (r < 95) w.debounce_time = $urandom_range(1000, 100000);
    else w.debounce_time = $urandom;
    return w;
  endfunction

  initial begin
    tx_idle_on = 1'b0;
    rx_stall_on = 1'b0;
    hold_off_req = 1'b0;
    quiet_cycles = 0;
    wall_ms = '0;
    foreach (sent_by_func[i]) sent_by_func[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, pin limits, edge matching, debounce with wrap, full table
    issue(FN_TAKE,  5'd0,  1'b0, 1'b0, 32'd0,          EM_RISE,   32'd0);
    issue(FN_EVENT, 5'd0,  1'b1, 1'b1, 32'd0,          EM_RISE,   32'd0);
    issue(FN_REM,   5'd3,  1'b0, 1'b0, 32'd0,          EM_RISE,   32'd0);
    issue(FN_ADD,   5'd0,  1'b0, 1'b0, 32'd0,          EM_RISE,   32'd0);
    issue(FN_ADD,   5'd29, 1'b0, 1'b0, 32'd0,          EM_EITHER, 32'hFFFF_FFFF);
    issue(FN_ADD,   5'd30, 1'b0, 1'b0, 32'd0,          EM_RISE,   32'd0);
    issue(FN_ADD,   5'd31, 1'b1, 1'b1, 32'hFFFF_FFFF,  EM_FALL,   32'd7);
    issue(FN_EVENT, 5'd0,  1'b1, 1'b0, 32'd0,          EM_RISE,   32'd0);
    issue(FN_EVENT, 5'd0,  1'b0, 1'b1, 32'd5,          EM_RISE,   32'd0);
    issue(FN_EVENT, 5'd29, 1'b1, 1'b0, 32'd0,          EM_RISE,   32'd0);
    issue(FN_EVENT, 5'd29, 1'b0, 1'b1, 32'hFFFF_FFFF,  EM_RISE,   32'd0);
    issue(FN_ADD,   5'd5,  1'b0, 1'b0, 32'd0,          EM_NONE,   32'd0);
    issue(FN_EVENT, 5'd5,  1'b1, 1'b1, 32'd10,         EM_RISE,   32'd0);
    issue(FN_ADD,   5'd5,  1'b0, 1'b0, 32'd0,          EM_FALL,   32'd100);
    issue(FN_EVENT, 5'd5,  1'b0, 1'b1, 32'd50,         EM_RISE,   32'd0);
    issue(FN_EVENT, 5'd5,  1'b0, 1'b1, 32'd100,        EM_RISE,   32'd0);
    issue(FN_EVENT, 5'd5,  1'b0, 1'b1, 32'hFFFF_FFF0,  EM_RISE,   32'd0);
    issue(FN_EVENT, 5'd5,  1'b0, 1'b1, 32'd20,         EM_RISE,   32'd0);
    issue(FN_SPARE5, 5'd5, 1'b1, 1'b1, 32'd0,          EM_NONE,   32'd0);
    issue(FN_SPARE7, 5'd0, 1'b0, 1'b0, 32'd0,          EM_RISE,   32'd0);
    for (int p = 10; p < 15; p++)
      issue(FN_ADD, 5'(p), 1'b0, 1'b0, 32'd0, EM_EITHER, 32'd0);
    issue(FN_ADD,   5'd15, 1'b0, 1'b0, 32'd0,          EM_RISE,   32'd0);
    issue(FN_ADD,   5'd10, 1'b0, 1'b0, 32'd0,          EM_FALL,   32'd3);
    issue(FN_REM,   5'd29, 1'b0, 1'b0, 32'd0,          EM_RISE,   32'd0);
    issue(FN_CLEAR, 5'd0,  1'b0, 1'b0, 32'd0,          EM_RISE,   32'd0);

    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      tx_idle_on  = (chunk % 3 != 0) && (chunk != 4);
      rx_stall_on = (chunk % 4 != 0);
      // block fills up and stalls its input while the receiver holds off
      if (chunk == 4) hold_off_req = 1'b1;
      for (int n = 0; n < CHUNK_WORDS; n++) send_word(random_command());
      if (chunk % 3 == 2) begin
        in_valid <= 1'b0;
        while (due_count != 0) @(negedge clk);
      end
    end

    in_valid <= 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Sent %0d edge events, %0d adds, %0d removes, %0d clears, %0d takes, %0d spare codes",
             sent_by_func[FN_EVENT], sent_by_func[FN_ADD], sent_by_func[FN_REM],
             sent_by_func[FN_CLEAR], sent_by_func[FN_TAKE],
             sent_by_func[FN_SPARE5] + sent_by_func[FN_SPARE6] + sent_by_func[FN_SPARE7]);
    $display("Checked %0d result words, %0d with newly fired slots, %0d mismatches",
             results_checked, firing_results, mismatches);
    if (mismatches == 0 && due_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/gebd_pkg.sv
design/gebd_deb_cmp.sv
design/gpio_edge_binding_debouncer.sv
tb/gebd_checker.sv
tb/tb.sv
